FILE: sv/kss_pkg.sv
// kss_pkg: shared types, widths and helpers for the sliding kurtosis/skewness core
// no dependencies; imported by the interfaces and every module of the block
package kss_pkg;

   // sample and window geometry
   localparam int SAMPLE_BITS = 24;
   localparam int WINDOW_MAX  = 256;
   localparam int PTR_W       = 8;
   localparam int LEN_W       = 9;
   localparam int LEN_MIN     = 2;
   localparam int LEN_RESET   = 64;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [LEN_W-1:0]              len_type;
   typedef logic [PTR_W-1:0]              ptr_type;
   typedef logic signed [31:0]            q16_type;

   // one queued sample with everything the back end needs
   typedef struct packed {
      sample_type sample;
      len_type    n;
      ptr_type    wp;
      logic       valid;
   } job_type;

   // queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // clamp the programmed window length to the supported range
   function automatic len_type eff_len(input len_type raw);
      len_type l;
      l = raw;
      if (raw < LEN_W'(LEN_MIN)) begin
         l = LEN_W'(LEN_MIN);
      end
      if (raw > LEN_W'(WINDOW_MAX)) begin
         l = LEN_W'(WINDOW_MAX);
      end
      return l;
   endfunction

endpackage

FILE: sv/kss_intf.sv
// kss_intf: valid/ready channel interfaces for sample requests and results
// depends on kss_pkg for the payload types
interface kss_req_if;
   import kss_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface kss_rsp_if;
   import kss_pkg::*;
   logic    valid;
   logic    ready;
   q16_type kurt_value;
   q16_type skew_value;
   logic    valid_res;
   logic    flat;
   modport source (output valid, output kurt_value, output skew_value,
                   output valid_res, output flat, input ready);
   modport sink   (input valid, input kurt_value, input skew_value,
                   input valid_res, input flat, output ready);
endinterface

FILE: sv/kss_front.sv
// kss_front: takes sample transfers, holds the window length register, tags each job
// depends on kss_pkg and kss_req_if
module kss_front (
   input  logic               clock,
   input  logic               reset,
   kss_req_if.sink            req_bus,
   input  logic               csr_wr_en,
   input  kss_pkg::len_type   csr_wr_data,
   input  kss_pkg::qstat_type qstat,
   output logic               push,
   output kss_pkg::job_type   push_job
);
   import kss_pkg::*;

   len_type len_ff, len_in;
   ptr_type wp_ff, wp_in;
   len_type fill_ff, fill_in;
   len_type n_eff;

   assign n_eff         = eff_len(len_ff);
   assign req_bus.ready = !qstat.full;
   assign push          = req_bus.valid && req_bus.ready;

   // job tag: window length, store slot and whether a full window precedes it
   assign push_job.sample = req_bus.sample;
   assign push_job.n      = n_eff;
   assign push_job.wp     = wp_ff;
   assign push_job.valid  = (fill_ff >= n_eff);

   // pointer advances on every accepted transfer; fill count too, until it reaches WINDOW_MAX
   always_comb begin
      len_in  = csr_wr_en ? csr_wr_data : len_ff;
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (push) begin
         wp_in = wp_ff + PTR_W'(1);
         if (fill_ff != LEN_W'(WINDOW_MAX)) begin
            fill_in = fill_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_W'(LEN_RESET);
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         len_ff  <= len_in;
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

endmodule

FILE: sv/kss_queue.sv
// kss_queue: two-entry job queue between the front end and the back end
// depends on kss_pkg
module kss_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  kss_pkg::job_type   push_job,
   input  logic               pop,
   output kss_pkg::job_type   pop_job,
   output kss_pkg::qstat_type qstat
);
   import kss_pkg::*;

   localparam int DEPTH = 2;

   job_type    slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == 2'(DEPTH));
   assign qstat.empty = (cnt_ff == 2'd0);
   assign pop_job     = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/kss_back.sv
// kss_back: window store, two read passes, moment pipeline, serial multiply and divide
// depends on kss_pkg and kss_rsp_if
module kss_back (
   input  logic               clock,
   input  logic               reset,
   input  kss_pkg::qstat_type qstat,
   output logic               pop,
   input  kss_pkg::job_type   pop_job,
   kss_rsp_if.source          rsp_bus
);
   import kss_pkg::*;

   // datapath widths
   localparam int SUM_W  = 32;
   localparam int E_W    = 34;
   localparam int M_W    = 33;
   localparam int SQ_W   = 65;
   localparam int CUBE_W = 97;
   localparam int QUAD_W = 129;
   localparam int E2_W   = 73;
   localparam int E3_W   = 106;
   localparam int E4_W   = 137;
   localparam int MA_W   = 220;
   localparam int MB_W   = 105;
   localparam int DEN_W  = 145;
   localparam int C_W    = 217;
   localparam int REM_W  = 161;
   localparam int DSH_W  = 192;
   localparam int SNUM_W = 249;
   localparam int SK_W   = 284;
   localparam int KQ_W   = 48;
   localparam int SQB_W  = 30;
   localparam int KD_W   = 50;
   localparam logic signed [KD_W-1:0] KURT_OFFSET = 50'sd196608;
   localparam logic signed [KD_W-1:0] KD_MAX      = 50'sd2147483647;
   localparam logic signed [KD_W-1:0] KD_MIN      = -50'sd2147483648;

   // sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SUM  = 4'd1;
   localparam logic [3:0] ST_MOM  = 4'd2;
   localparam logic [3:0] ST_CHK  = 4'd3;
   localparam logic [3:0] ST_MUL  = 4'd4;
   localparam logic [3:0] ST_KDIV = 4'd5;
   localparam logic [3:0] ST_KFIN = 4'd6;
   localparam logic [3:0] ST_SKA  = 4'd7;
   localparam logic [3:0] ST_SKB  = 4'd8;
   localparam logic [3:0] ST_SFIN = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   // serial multiply operations
   localparam logic [2:0] OP_DEN  = 3'd0;
   localparam logic [2:0] OP_CUBE = 3'd1;
   localparam logic [2:0] OP_KNUM = 3'd2;
   localparam logic [2:0] OP_ASQ  = 3'd3;
   localparam logic [2:0] OP_SNUM = 3'd4;

   // window store
   sample_type store_mem [WINDOW_MAX];
   sample_type rd_data_ff;
   ptr_type    rd_addr;
   logic       rd_en;
   logic       mem_we;
   logic       rd_vld_ff, rd_vld_in;

   // sequencer registers
   logic [3:0]        state_ff, state_in;
   job_type           job_ff, job_in;
   len_type           iss_ff, iss_in;
   len_type           rcv_ff, rcv_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [E2_W-1:0]   e2_ff, e2_in;
   logic [E3_W-1:0]   e3_ff, e3_in;
   logic [E4_W-1:0]   e4_ff, e4_in;
   logic [MA_W-1:0]   mul_a_ff, mul_a_in;
   logic [MB_W-1:0]   mul_b_ff, mul_b_in;
   logic [MA_W-1:0]   acc_ff, acc_in;
   logic [2:0]        op_ff, op_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [C_W-1:0]    c_ff, c_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DSH_W-1:0]  dsh_ff, dsh_in;
   logic [KQ_W-1:0]   kq_ff, kq_in;
   logic [5:0]        bit_ff, bit_in;
   logic [SNUM_W-1:0] snum_ff, snum_in;
   logic [SK_W-1:0]   q2_ff, q2_in;
   logic [SK_W-1:0]   r_ff, r_in;
   logic [SK_W-1:0]   c2b_ff, c2b_in;
   logic [SK_W-1:0]   s1_ff, s1_in;
   logic [SK_W-1:0]   s2_ff, s2_in;
   logic [SQB_W-1:0]  sq_ff, sq_in;
   q16_type           kurt_ff, kurt_in;
   q16_type           skew_ff, skew_in;
   logic              flat_ff, flat_in;

   // result register
   logic    out_valid_ff, out_valid_in;
   q16_type out_kurt_ff, out_skew_ff;
   logic    out_vres_ff, out_flat_ff;
   logic    out_load;

   // moment pipeline
   logic [4:0]              pipe_v_ff, pipe_v_in;
   logic signed [9:0]       n_s;
   logic signed [E_W-1:0]   nx;
   logic signed [E_W-1:0]   e_s1_ff, e_s1_in;
   logic [M_W-1:0]          mag_s2_ff, mag_s2_in;
   logic                    neg_s2_ff;
   logic [SQ_W-1:0]         sq_s3_ff, sq_s3_in;
   logic [M_W-1:0]          mag_s3_ff;
   logic                    neg_s3_ff;
   logic [31:0]             sq_hi;
   logic [M_W-1:0]          sq_lo;
   logic [64:0]             p3h_s4_ff, p3h_s4_in;
   logic [65:0]             p3l_s4_ff, p3l_s4_in;
   logic [63:0]             phh_s4_ff, phh_s4_in;
   logic [64:0]             phl_s4_ff, phl_s4_in;
   logic [65:0]             pll_s4_ff, pll_s4_in;
   logic [SQ_W-1:0]         sq_s4_ff;
   logic                    neg_s4_ff;
   logic [SQ_W-1:0]         t2_s5_ff;
   logic [CUBE_W-1:0]       t3_s5_ff, t3_s5_in;
   logic [QUAD_W-1:0]       t4_s5_ff, t4_s5_in;
   logic                    neg_s5_ff;

   // stage 1: deviation scaled by window length
   assign n_s     = $signed({1'b0, job_ff.n});
   assign nx      = n_s * rd_data_ff;
   assign e_s1_in = nx - E_W'(sum_ff);

   // stage 2: magnitude and sign
   assign mag_s2_in = M_W'(e_s1_ff[E_W-1] ? -e_s1_ff : e_s1_ff);

   // stage 3: square
   assign sq_s3_in = mag_s2_ff * mag_s2_ff;

   // stage 4: partial products of cube and fourth power
   assign sq_hi     = sq_s3_ff[SQ_W-1:M_W];
   assign sq_lo     = sq_s3_ff[M_W-1:0];
   assign p3h_s4_in = sq_hi * mag_s3_ff;
   assign p3l_s4_in = sq_lo * mag_s3_ff;
   assign phh_s4_in = sq_hi * sq_hi;
   assign phl_s4_in = sq_hi * sq_lo;
   assign pll_s4_in = sq_lo * sq_lo;

   // stage 5: combine partial products
   assign t3_s5_in = (CUBE_W'(p3h_s4_ff) << M_W) + CUBE_W'(p3l_s4_ff);
   assign t4_s5_in = (QUAD_W'(phh_s4_ff) << (2 * M_W)) + (QUAD_W'(phl_s4_ff) << (M_W + 1))
                   + QUAD_W'(pll_s4_ff);

   assign pipe_v_in = {pipe_v_ff[3:0], rd_vld_ff && (state_ff == ST_MOM)};
   assign rd_vld_in = rd_en;
   assign rd_addr   = job_ff.wp - PTR_W'(1) - iss_ff[PTR_W-1:0];

   // response channel
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.kurt_value = out_kurt_ff;
   assign rsp_bus.skew_value = out_skew_ff;
   assign rsp_bus.valid_res  = out_vres_ff;
   assign rsp_bus.flat       = out_flat_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      logic                   take;
      logic [SK_W-1:0]        cand;
      logic signed [KD_W-1:0] kd;
      logic [E3_W-1:0]        e3_abs;

      take     = 1'b0;
      cand     = q2_ff + s1_ff;
      kd       = $signed({2'b00, kq_ff}) - KURT_OFFSET;
      e3_abs   = e3_ff[E3_W-1] ? -e3_ff : e3_ff;
      state_in = state_ff;
      job_in   = job_ff;
      iss_in   = iss_ff;
      rcv_in   = rcv_ff;
      sum_in   = sum_ff;
      e2_in    = e2_ff;
      e3_in    = e3_ff;
      e4_in    = e4_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      acc_in   = acc_ff;
      op_in    = op_ff;
      den_in   = den_ff;
      c_in     = c_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      kq_in    = kq_ff;
      bit_in   = bit_ff;
      snum_in  = snum_ff;
      q2_in    = q2_ff;
      r_in     = r_ff;
      c2b_in   = c2b_ff;
      s1_in    = s1_ff;
      s2_in    = s2_ff;
      sq_in    = sq_ff;
      kurt_in  = kurt_ff;
      skew_in  = skew_ff;
      flat_in  = flat_ff;
      rd_en    = 1'b0;
      pop      = 1'b0;
      mem_we   = 1'b0;
      out_load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               job_in   = pop_job;
               sum_in   = '0;
               iss_in   = '0;
               rcv_in   = '0;
               kurt_in  = '0;
               skew_in  = '0;
               flat_in  = 1'b0;
               state_in = pop_job.valid ? ST_SUM : ST_DONE;
            end
         end
         // first pass: window sum
         ST_SUM: begin
            rd_en = (iss_ff < job_ff.n);
            if (rd_en) begin
               iss_in = iss_ff + LEN_W'(1);
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + SUM_W'(rd_data_ff);
               rcv_in = rcv_ff + LEN_W'(1);
            end
            if (rcv_ff == job_ff.n) begin
               iss_in   = '0;
               rcv_in   = '0;
               e2_in    = '0;
               e3_in    = '0;
               e4_in    = '0;
               state_in = ST_MOM;
            end
         end
         // second pass: power sums through the moment pipeline
         ST_MOM: begin
            rd_en = (iss_ff < job_ff.n);
            if (rd_en) begin
               iss_in = iss_ff + LEN_W'(1);
            end
            if (pipe_v_ff[4]) begin
               e2_in  = e2_ff + E2_W'(t2_s5_ff);
               e3_in  = neg_s5_ff ? e3_ff - E3_W'(t3_s5_ff) : e3_ff + E3_W'(t3_s5_ff);
               e4_in  = e4_ff + E4_W'(t4_s5_ff);
               rcv_in = rcv_ff + LEN_W'(1);
            end
            if (rcv_ff == job_ff.n) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (e2_ff == '0) begin
               flat_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               mul_a_in = MA_W'(e2_ff);
               mul_b_in = MB_W'(e2_ff);
               acc_in   = '0;
               op_in    = OP_DEN;
               state_in = ST_MUL;
            end
         end
         // shift-and-add multiply, one multiplier bit a cycle
         ST_MUL: begin
            if (mul_b_ff != '0) begin
               if (mul_b_ff[0]) begin
                  acc_in = acc_ff + mul_a_ff;
               end
               mul_a_in = mul_a_ff << 1;
               mul_b_in = mul_b_ff >> 1;
            end else begin
               case (op_ff)
                  OP_DEN: begin
                     den_in   = acc_ff[DEN_W-1:0];
                     mul_a_in = acc_ff;
                     mul_b_in = MB_W'(e2_ff);
                     acc_in   = '0;
                     op_in    = OP_CUBE;
                  end
                  OP_CUBE: begin
                     c_in     = acc_ff[C_W-1:0];
                     mul_a_in = MA_W'(e4_ff);
                     mul_b_in = MB_W'(job_ff.n);
                     acc_in   = '0;
                     op_in    = OP_KNUM;
                  end
                  OP_KNUM: begin
                     rem_in   = {acc_ff[DEN_W-1:0], 16'd0};
                     dsh_in   = {den_ff, 47'd0};
                     kq_in    = '0;
                     bit_in   = 6'(KQ_W - 1);
                     state_in = ST_KDIV;
                  end
                  OP_ASQ: begin
                     mul_a_in = acc_ff;
                     mul_b_in = MB_W'(job_ff.n);
                     acc_in   = '0;
                     op_in    = OP_SNUM;
                  end
                  OP_SNUM: begin
                     snum_in  = {acc_ff[C_W-1:0], 32'd0};
                     q2_in    = '0;
                     r_in     = '0;
                     c2b_in   = SK_W'({c_ff, 58'd0});
                     sq_in    = '0;
                     bit_in   = 6'(SQB_W - 1);
                     state_in = ST_SKA;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         // restoring division for kurtosis, one quotient bit a cycle
         ST_KDIV: begin
            take = (dsh_ff <= DSH_W'(rem_ff));
            if (take) begin
               rem_in = rem_ff - dsh_ff[REM_W-1:0];
            end
            kq_in  = {kq_ff[KQ_W-2:0], take};
            dsh_in = dsh_ff >> 1;
            if (bit_ff == 6'd0) begin
               state_in = ST_KFIN;
            end else begin
               bit_in = bit_ff - 6'd1;
            end
         end
         // offset by three, round toward zero, saturate; start the skewness multiply if e3 is nonzero
         ST_KFIN: begin
            if (kd[KD_W-1] && (rem_ff != '0)) begin
               kd = kd + KD_W'(1);
            end
            if (kd > KD_MAX) begin
               kurt_in = KD_MAX[31:0];
            end else if (kd < KD_MIN) begin
               kurt_in = KD_MIN[31:0];
            end else begin
               kurt_in = kd[31:0];
            end
            if (e3_ff != '0) begin
               mul_a_in = MA_W'(e3_abs);
               mul_b_in = e3_abs[MB_W-1:0];
               acc_in   = '0;
               op_in    = OP_ASQ;
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         // skewness root search: candidate terms
         ST_SKA: begin
            s1_in    = r_ff + c2b_ff;
            s2_in    = r_ff + (c2b_ff << 1);
            state_in = ST_SKB;
         end
         // skewness root search: compare and keep
         ST_SKB: begin
            take = (cand <= SK_W'(snum_ff));
            if (take) begin
               q2_in = cand;
               r_in  = s2_ff >> 1;
            end else begin
               r_in  = r_ff >> 1;
            end
            sq_in  = {sq_ff[SQB_W-2:0], take};
            c2b_in = c2b_ff >> 2;
            if (bit_ff == 6'd0) begin
               state_in = ST_SFIN;
            end else begin
               bit_in   = bit_ff - 6'd1;
               state_in = ST_SKA;
            end
         end
         ST_SFIN: begin
            skew_in  = e3_ff[E3_W-1] ? -(32'(sq_ff)) : 32'(sq_ff);
            state_in = ST_DONE;
         end
         // store the sample and hand the result over
         ST_DONE: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               mem_we   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         pipe_v_ff    <= '0;
         iss_ff       <= '0;
         rcv_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         rd_vld_ff    <= rd_vld_in;
         pipe_v_ff    <= pipe_v_in;
         iss_ff       <= iss_in;
         rcv_ff       <= rcv_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      sum_ff   <= sum_in;
      e2_ff    <= e2_in;
      e3_ff    <= e3_in;
      e4_ff    <= e4_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      acc_ff   <= acc_in;
      op_ff    <= op_in;
      den_ff   <= den_in;
      c_ff     <= c_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      kq_ff    <= kq_in;
      bit_ff   <= bit_in;
      snum_ff  <= snum_in;
      q2_ff    <= q2_in;
      r_ff     <= r_in;
      c2b_ff   <= c2b_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      sq_ff    <= sq_in;
      kurt_ff  <= kurt_in;
      skew_ff  <= skew_in;
      flat_ff  <= flat_in;
      if (out_load) begin
         out_kurt_ff <= kurt_ff;
         out_skew_ff <= skew_ff;
         out_vres_ff <= job_ff.valid;
         out_flat_ff <= flat_ff;
      end
   end

   // moment pipeline registers
   always_ff @(posedge clock) begin
      e_s1_ff   <= e_s1_in;
      mag_s2_ff <= mag_s2_in;
      neg_s2_ff <= e_s1_ff[E_W-1];
      sq_s3_ff  <= sq_s3_in;
      mag_s3_ff <= mag_s2_ff;
      neg_s3_ff <= neg_s2_ff;
      p3h_s4_ff <= p3h_s4_in;
      p3l_s4_ff <= p3l_s4_in;
      phh_s4_ff <= phh_s4_in;
      phl_s4_ff <= phl_s4_in;
      pll_s4_ff <= pll_s4_in;
      sq_s4_ff  <= sq_s3_ff;
      neg_s4_ff <= neg_s3_ff;
      t2_s5_ff  <= sq_s4_ff;
      t3_s5_ff  <= t3_s5_in;
      t4_s5_ff  <= t4_s5_in;
      neg_s5_ff <= neg_s4_ff;
   end

   // window store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[job_ff.wp] <= job_ff.sample;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

endmodule

FILE: sv/sliding_kurtosis_skewness_core.sv
// sliding_kurtosis_skewness_core: top level of the sliding kurtosis/skewness block
// depends on kss_pkg, kss_intf, kss_front, kss_queue, kss_back
//
//   channel   direction  handshake          payload
//   req_bus   in         valid/ready        sample (24b signed)
//   rsp_bus   out        valid/ready        kurt_value, skew_value (Q15.16), valid_res, flat
//   csr_*     in         write enable only  window_len (9b)
//
// A sample with a full window behind it goes through two read passes over the store port, then
// a one-bit-a-cycle multiplier, a 48-step divider and a 30-step root search, one after another.
// Samples before the window fills skip the computation in the back end. Reset is synchronous;
// the store needs no clearing pass. The two-entry queue keeps taking samples while the back end
// works, and a waiting result only stalls the back end when it must hand over the next one.
module sliding_kurtosis_skewness_core (
   input  logic             clock,
   input  logic             reset,
   kss_req_if.sink          req_bus,
   kss_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  kss_pkg::len_type csr_wr_data
);
   import kss_pkg::*;

   logic      push;
   logic      pop;
   job_type   push_job;
   job_type   pop_job;
   qstat_type qstat;

   // intake and tagging
   kss_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .qstat       (qstat),
      .push        (push),
      .push_job    (push_job)
   );

   // job queue
   kss_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .qstat    (qstat)
   );

   // statistics engine
   kss_back u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat   (qstat),
      .pop     (pop),
      .pop_job (pop_job),
      .rsp_bus (rsp_bus)
   );

endmodule
